### rtl/core/assert_macros.svh
// Assertion helpers for the bank mapper. Every check is sampled on the rising
// edge of clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every sampled edge.
`define BMI_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define BMI_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

### rtl/core/bmi_pkg.sv
// ----------------------------------------------------------------------------
// bmi_pkg
// Shared types and constants of the bank mapper: item kinds, register
// indexes, write decode codes and the decoded write command.
// ----------------------------------------------------------------------------
package bmi_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_PRG   = 2'd2,
    MODE_CHR   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_LINE0_MASK   = 2'd0,
    CFG_LINE1_MASK   = 2'd1,
    CFG_FULL_VARIANT = 2'd2,
    CFG_HONOR_REPEAT = 2'd3
  } cfg_idx_t;

  // Upper address nibble of register writes.
  localparam logic [3:0] HI_PRG0     = 4'h8;
  localparam logic [3:0] HI_MIRROR   = 4'h9;
  localparam logic [3:0] HI_PRG1     = 4'hA;
  localparam logic [3:0] HI_CHR_BASE = 4'hB;
  localparam logic [3:0] HI_IRQ      = 4'hF;

  // Select-line codes, line 1 in the upper bit.
  localparam logic [1:0] SEL_NONE  = 2'd0;
  localparam logic [1:0] SEL_LINE0 = 2'd1;
  localparam logic [1:0] SEL_LINE1 = 2'd2;
  localparam logic [1:0] SEL_BOTH  = 2'd3;

  localparam logic signed [9:0] PRESCALE_RELOAD = 10'sd341;
  localparam logic signed [9:0] PRESCALE_STEP   = 10'sd3;
  localparam logic [6:0]        PRG_FIXED_HI    = 7'h7F;  // banks 0xFE and 0xFF

  typedef struct packed {
    logic       prg_we;
    logic       prg_sel;
    logic       mirror_we;
    logic       misc_we;
    logic       chr_we;
    logic [2:0] chr_idx;
    logic       chr_hi;
    logic       reload_lo_we;
    logic       reload_hi_we;
    logic       ctrl_we;
    logic       ack;
    logic       ack_rpt;
    logic       tick;
    logic [7:0] data;
  } wr_cmd_t;

endpackage

### rtl/core/bmi_decode.sv
// ----------------------------------------------------------------------------
// bmi_decode
// Turns one registered item into a set of register write strobes and a
// cycle tick, using the two select-line masks.
// ----------------------------------------------------------------------------
module bmi_decode
  import bmi_pkg::*;
(
  input  logic        fire,
  input  mode_t       mode,
  input  logic [15:0] address,
  input  logic [7:0]  value,
  input  logic [15:0] line0_mask,
  input  logic [15:0] line1_mask,
  input  logic        full_variant,
  input  logic        honor_repeat,
  output wr_cmd_t     cmd
);

  logic       wr_ok;
  logic [3:0] hi;
  logic [1:0] sel;
  logic [3:0] chr_off;

  assign hi      = address[15:12];
  assign sel     = {|(address & line1_mask), |(address & line0_mask)};
  assign wr_ok   = fire && (mode == MODE_WRITE) && address[15];
  assign chr_off = hi - HI_CHR_BASE;

  always_comb begin
    cmd         = '0;
    cmd.data    = value;
    cmd.prg_sel = hi[1];
    cmd.chr_idx = {chr_off[1:0], sel[1]};
    cmd.chr_hi  = sel[0];
    cmd.tick    = fire && (mode == MODE_TICK) && full_variant;
    if (wr_ok) begin
      unique case (hi)
        HI_PRG0, HI_PRG1: cmd.prg_we = 1'b1;
        HI_MIRROR: begin
          if (!full_variant || sel == SEL_NONE) begin
            cmd.mirror_we = 1'b1;
          end else if (sel == SEL_LINE1) begin
            cmd.misc_we = 1'b1;
          end
        end
        HI_IRQ: begin
          if (full_variant) begin
            unique case (sel)
              SEL_NONE:  cmd.reload_lo_we = 1'b1;
              SEL_LINE0: cmd.reload_hi_we = 1'b1;
              SEL_LINE1: cmd.ctrl_we      = 1'b1;
              SEL_BOTH: begin
                cmd.ack     = 1'b1;
                cmd.ack_rpt = honor_repeat;
              end
              default:   cmd.ack          = 1'b0;
            endcase
          end
        end
        default: cmd.chr_we = 1'b1;
      endcase
    end
  end

endmodule

### rtl/core/bmi_bank_regs.sv
// ----------------------------------------------------------------------------
// bmi_bank_regs
// PRG and CHR bank registers, mirroring and misc bits, and the bank lookup
// for query items.
// ----------------------------------------------------------------------------
module bmi_bank_regs
  import bmi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  wr_cmd_t     cmd,
  input  mode_t       mode,
  input  logic [15:0] address,
  input  logic        full_variant,
  output logic [11:0] bank,
  output logic [1:0]  mirror_nxt,
  output logic [1:0]  misc_nxt
);

  logic [7:0]  prg_r [2];
  logic [11:0] chr_r [8];
  logic [1:0]  mirror_r;
  logic [1:0]  misc_r;
  logic [1:0]  slot;

  assign mirror_nxt = cmd.mirror_we ? cmd.data[1:0] : mirror_r;
  assign misc_nxt   = cmd.misc_we   ? cmd.data[1:0] : misc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_r[0] <= '0;
      prg_r[1] <= '0;
      for (int i = 0; i < 8; i++) begin
        chr_r[i] <= 12'(i);
      end
      mirror_r <= '0;
      misc_r   <= 2'd1;
    end else begin
      mirror_r <= mirror_nxt;
      misc_r   <= misc_nxt;
      if (cmd.prg_we) begin
        prg_r[cmd.prg_sel] <= cmd.data;
      end
      if (cmd.chr_we) begin
        if (cmd.chr_hi) begin
          chr_r[cmd.chr_idx][11:4] <= cmd.data;
        end else begin
          chr_r[cmd.chr_idx][3:0] <= cmd.data[3:0];
        end
      end
    end
  end

  // With PRG swap on, the two even slots trade places.
  always_comb begin
    slot = address[14:13];
    if (full_variant && !slot[0] && misc_r[1]) begin
      slot[1] = ~slot[1];
    end
  end

  always_comb begin
    unique case (mode)
      MODE_PRG: begin
        if (slot[1]) begin
          bank = {4'd0, PRG_FIXED_HI, slot[0]};
        end else begin
          bank = {4'd0, prg_r[slot[0]]};
        end
      end
      MODE_CHR: bank = chr_r[address[12:10]];
      default:  bank = '0;
    endcase
  end

endmodule

### rtl/core/bmi_irq_counter.sv
// ----------------------------------------------------------------------------
// bmi_irq_counter
// IRQ latch, control bits, 8-bit counter with 341/3 prescaler and the
// interrupt flag.
// ----------------------------------------------------------------------------
module bmi_irq_counter
  import bmi_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  wr_cmd_t cmd,
  output logic    flag_nxt
);

  logic [7:0]        reload_r, reload_nxt;
  logic [2:0]        ctrl_r, ctrl_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic signed [9:0] pre_r, pre_nxt;
  logic              flag_r;
  logic signed [9:0] pre_dec;
  logic [7:0]        cnt_inc;
  logic              step;

  assign pre_dec = pre_r - PRESCALE_STEP;
  assign cnt_inc = cnt_r + 8'd1;

  always_comb begin
    reload_nxt = reload_r;
    ctrl_nxt   = ctrl_r;
    cnt_nxt    = cnt_r;
    pre_nxt    = pre_r;
    flag_nxt   = flag_r;
    step       = 1'b0;
    if (cmd.reload_lo_we) begin
      reload_nxt[3:0] = cmd.data[3:0];
    end
    if (cmd.reload_hi_we) begin
      reload_nxt[7:4] = cmd.data[3:0];
    end
    if (cmd.ctrl_we) begin
      ctrl_nxt = cmd.data[2:0];
      if (cmd.data[1]) begin
        cnt_nxt = reload_r;
        pre_nxt = PRESCALE_RELOAD;
      end
      flag_nxt = 1'b0;
    end
    if (cmd.ack) begin
      if (cmd.ack_rpt) begin
        ctrl_nxt[1] = ctrl_r[0];
      end
      flag_nxt = 1'b0;
    end
    if (cmd.tick && ctrl_r[1]) begin
      // Cycle mode counts every tick; scanline mode every 341/3 ticks.
      if (ctrl_r[2]) begin
        step = 1'b1;
      end else begin
        step = (pre_dec <= 10'sd0);
        pre_nxt = step ? (pre_dec + PRESCALE_RELOAD) : pre_dec;
      end
      if (step) begin
        if (cnt_inc == 8'd0) begin
          cnt_nxt  = reload_r;
          flag_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= '0;
      ctrl_r   <= '0;
      cnt_r    <= '0;
      pre_r    <= '0;
      flag_r   <= 1'b0;
    end else begin
      reload_r <= reload_nxt;
      ctrl_r   <= ctrl_nxt;
      cnt_r    <= cnt_nxt;
      pre_r    <= pre_nxt;
      flag_r   <= flag_nxt;
    end
  end

endmodule

### rtl/core/bank_mapper_with_cycle_irq_unit.sv
// ----------------------------------------------------------------------------
// bank_mapper_with_cycle_irq_unit
// Cartridge bank mapper with a CPU-cycle IRQ counter: register writes,
// cycle ticks and PRG/CHR bank queries, one result per item.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// in_*      input      tuser: mode; tdata: address, value
// out_*     output     tdata: bank, mirror_code, wram_enable, irq_line
// cfg_*     input      register index and data, written when cfg_we is high
//
// Each item waits in the input register until the result register is free, and
// is then decoded, applied to the state and captured in the result register in
// the same cycle. One item per cycle is sustained while out_tready stays high.
// Reset is synchronous on rst_n and restores the mapper state and valid flags.
// A stalled output holds the result; the input register still drains into the
// output register as soon as it frees up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bank_mapper_with_cycle_irq_unit
  import bmi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // address[15:0], value[23:16]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // bank[11:0], mirror_code[13:12],
                                  // wram_enable[14], irq_line[15]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] line0_mask_r;
  logic [15:0] line1_mask_r;
  logic        full_variant_r;
  logic        honor_repeat_r;

  logic        s1_vld_r;
  mode_t       s1_mode_r;
  logic [15:0] s1_addr_r;
  logic [7:0]  s1_value_r;

  logic        out_vld_r;
  logic [15:0] out_data_r;

  logic        advance;
  wr_cmd_t     cmd;
  logic [11:0] bank;
  logic [1:0]  mirror_nxt;
  logic [1:0]  misc_nxt;
  logic        flag_nxt;
  logic [1:0]  mirror_code;
  logic        wram_enable;

  assign advance   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line0_mask_r   <= 16'd1;
      line1_mask_r   <= 16'd2;
      full_variant_r <= 1'b1;
      honor_repeat_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_LINE0_MASK:   line0_mask_r   <= cfg_wdata;
        CFG_LINE1_MASK:   line1_mask_r   <= cfg_wdata;
        CFG_FULL_VARIANT: full_variant_r <= cfg_wdata[0];
        CFG_HONOR_REPEAT: honor_repeat_r <= cfg_wdata[0];
        default:          honor_repeat_r <= honor_repeat_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_mode_r  <= mode_t'(in_tuser);
      s1_addr_r  <= in_tdata[15:0];
      s1_value_r <= in_tdata[23:16];
    end
  end

  bmi_decode u_decode (
    .fire         (advance),
    .mode         (s1_mode_r),
    .address      (s1_addr_r),
    .value        (s1_value_r),
    .line0_mask   (line0_mask_r),
    .line1_mask   (line1_mask_r),
    .full_variant (full_variant_r),
    .honor_repeat (honor_repeat_r),
    .cmd          (cmd)
  );

  bmi_bank_regs u_bank_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .mode         (s1_mode_r),
    .address      (s1_addr_r),
    .full_variant (full_variant_r),
    .bank         (bank),
    .mirror_nxt   (mirror_nxt),
    .misc_nxt     (misc_nxt)
  );

  bmi_irq_counter u_irq_counter (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .flag_nxt (flag_nxt)
  );

  // Results reflect the state after the item has been applied.
  assign mirror_code = (full_variant_r && mirror_nxt[1]) ? {1'b1, mirror_nxt[0]}
                                                         : {1'b0, mirror_nxt[0]};
  assign wram_enable = misc_nxt[0] || !full_variant_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {flag_nxt, wram_enable, mirror_code, bank};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  `BMI_ASSERT_NEXT(a_hold_item, s1_vld_r && out_vld_r && !out_tready, s1_vld_r,
                   "pending item dropped while output stalled")
  `BMI_ASSERT_NEXT(a_result_follows, advance, out_tvalid,
                   "processed item produced no result")
  `BMI_ASSERT_NEXT(a_no_bank_on_write, advance && (s1_mode_r == MODE_WRITE ||
                   s1_mode_r == MODE_TICK), out_tdata[11:0] == 12'd0,
                   "non-query item returned a bank number")
  `BMI_ASSERT_NEXT(a_wram_reduced, advance && !full_variant_r, out_tdata[14],
                   "reduced variant must keep work RAM enabled")

endmodule

### dv/bank_mapper_with_cycle_irq_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bank_mapper_with_cycle_irq_unit_tb
// Self-checking bench for the bank mapper. A short table of directed items
// covers reset values, the fixed PRG banks, ignored writes and one interrupt
// sequence. Random phases follow under several mask and variant settings.
// Every accepted item runs through a local model of the mapper, and each
// output transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bank_mapper_with_cycle_irq_unit_tb;
  import bmi_pkg::*;

  typedef struct packed {
    logic        irq;
    logic        wram;
    logic [1:0]  mc;
    logic [11:0] bank;
  } result_t;

  typedef struct packed {
    mode_t       m;
    logic [15:0] a;
    logic [7:0]  v;
    logic        typed;
    result_t     want;
  } dir_row_t;

  localparam int NDIR      = 26;
  localparam int NPHASE    = 6;
  localparam int PHASE_LEN = 305;
  localparam int WD_LIMIT  = 2000;

  // Rows with typed set carry their expected result; the rest use the model.
  localparam dir_row_t DIR_TBL [NDIR] = '{
    '{MODE_CHR,   16'h0000, 8'h00, 1'b1, '{1'b0, 1'b1, 2'd0, 12'h000}},
    '{MODE_CHR,   16'hFC00, 8'h00, 1'b1, '{1'b0, 1'b1, 2'd0, 12'h007}},
    '{MODE_PRG,   16'hC000, 8'h00, 1'b1, '{1'b0, 1'b1, 2'd0, 12'h0FE}},
    '{MODE_PRG,   16'h6000, 8'h00, 1'b1, '{1'b0, 1'b1, 2'd0, 12'h0FF}},
    '{MODE_PRG,   16'h8000, 8'h00, 1'b1, '{1'b0, 1'b1, 2'd0, 12'h000}},
    '{MODE_WRITE, 16'h7FFF, 8'hFF, 1'b1, '{1'b0, 1'b1, 2'd0, 12'h000}},
    '{MODE_WRITE, 16'h8000, 8'hFF, 1'b0, '0},
    '{MODE_WRITE, 16'hA003, 8'h5A, 1'b0, '0},
    '{MODE_PRG,   16'hA000, 8'h00, 1'b0, '0},
    '{MODE_WRITE, 16'h9000, 8'hFF, 1'b0, '0},
    '{MODE_WRITE, 16'h9002, 8'hFE, 1'b0, '0},
    '{MODE_PRG,   16'h8000, 8'h00, 1'b0, '0},
    '{MODE_WRITE, 16'h9003, 8'h00, 1'b0, '0},
    '{MODE_WRITE, 16'hB000, 8'hFF, 1'b0, '0},
    '{MODE_WRITE, 16'hE003, 8'hFF, 1'b0, '0},
    '{MODE_CHR,   16'h1C00, 8'h00, 1'b0, '0},
    '{MODE_WRITE, 16'hF000, 8'h0E, 1'b0, '0},
    '{MODE_WRITE, 16'hF001, 8'h0F, 1'b0, '0},
    '{MODE_WRITE, 16'hF002, 8'h07, 1'b0, '0},
    '{MODE_TICK,  16'hFFFF, 8'hFF, 1'b0, '0},
    '{MODE_TICK,  16'h0000, 8'h00, 1'b0, '0},
    '{MODE_WRITE, 16'hF000, 8'h00, 1'b0, '0},
    '{MODE_WRITE, 16'hF003, 8'h00, 1'b0, '0},
    '{MODE_WRITE, 16'hF002, 8'h02, 1'b0, '0},
    '{MODE_TICK,  16'h1234, 8'h00, 1'b0, '0},
    '{MODE_WRITE, 16'h9002, 8'h01, 1'b0, '0}
  };

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // address[15:0], value[23:16]
  logic [1:0]  in_tuser   = '0;   // mode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // bank[11:0], mirror_code[13:12],
                                  // wram_enable[14], irq_line[15]
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_addr   = '0;
  logic [15:0] cfg_wdata  = '0;

  // Travels with the item on the bus so the monitor knows a typed expectation.
  logic        item_typed = 1'b0;
  result_t     item_want  = '0;

  int send_pct = 0;
  int recv_pct = 0;
  int err_cnt = 0;
  int n_results = 0;
  int n_irq_seen = 0;
  int n_cfg = 0;
  int idle_cycles = 0;

  result_t bank_result_q [$];

  // Local copy of the mapper state and its configuration.
  logic [15:0] sel0_mask, sel1_mask;
  logic        full_mode, repeat_en;
  logic [7:0]  prg_bank_q [2];
  logic [11:0] chr_bank_q [8];
  logic [1:0]  mirror_q, misc_q;
  logic [7:0]  irq_latch, irq_cnt;
  logic [2:0]  irq_ctl;
  int          presc;
  logic        irq_pend;

  bank_mapper_with_cycle_irq_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic result_t map_item(mode_t m, logic [15:0] a, logic [7:0] v);
    logic [1:0] sel;
    logic [3:0] nib;
    logic [3:0] off;
    logic [2:0] idx;
    logic [1:0] slot;
    logic       fire;
    result_t    r;
    r = '0;
    fire = 1'b0;
    nib = a[15:12];
    sel = {|(a & sel1_mask), |(a & sel0_mask)};
    case (m)
      MODE_WRITE: begin
        if (a[15]) begin
          case (nib)
            HI_PRG0, HI_PRG1: prg_bank_q[nib[1]] = v;
            HI_MIRROR: begin
              if (!full_mode || sel == SEL_NONE) mirror_q = v[1:0];
              else if (sel == SEL_LINE1) misc_q = v[1:0];
            end
            HI_IRQ: begin
              if (full_mode) begin
                case (sel)
                  SEL_NONE:  irq_latch[3:0] = v[3:0];
                  SEL_LINE0: irq_latch[7:4] = v[3:0];
                  SEL_LINE1: begin
                    irq_ctl = v[2:0];
                    if (irq_ctl[1]) begin
                      irq_cnt = irq_latch;
                      presc = PRESCALE_RELOAD;
                    end
                    irq_pend = 1'b0;
                  end
                  default: begin
                    // Acknowledge; with repeat the enable follows bit 0.
                    if (repeat_en) irq_ctl[1] = irq_ctl[0];
                    irq_pend = 1'b0;
                  end
                endcase
              end
            end
            default: begin
              off = nib - HI_CHR_BASE;
              idx = {off[1:0], sel[1]};
              if (sel[0]) chr_bank_q[idx][11:4] = v;
              else chr_bank_q[idx][3:0] = v[3:0];
            end
          endcase
        end
      end
      MODE_TICK: begin
        if (full_mode && irq_ctl[1]) begin
          if (irq_ctl[2]) begin
            fire = 1'b1;
          end else begin
            presc = presc - PRESCALE_STEP;
            fire = (presc <= 0);
            if (fire) presc = presc + PRESCALE_RELOAD;
          end
          if (fire) begin
            irq_cnt = irq_cnt + 8'd1;
            if (irq_cnt == 8'd0) begin
              irq_cnt = irq_latch;
              irq_pend = 1'b1;
            end
          end
        end
      end
      MODE_PRG: begin
        slot = a[14:13];
        if (full_mode && !slot[0] && misc_q[1]) slot[1] = ~slot[1];
        r.bank = slot[1] ? {4'h0, PRG_FIXED_HI, slot[0]} : {4'h0, prg_bank_q[slot[0]]};
      end
      default: r.bank = chr_bank_q[a[12:10]];
    endcase
    if (full_mode && mirror_q[1]) r.mc = {1'b1, mirror_q[0]};
    else r.mc = {1'b0, mirror_q[0]};
    r.wram = misc_q[0] || !full_mode;
    r.irq = irq_pend;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h", n_results, what, got, want);
    err_cnt++;
  endtask

  // Model update on accepted items and register writes, check on results.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      sel0_mask = 16'h0001;
      sel1_mask = 16'h0002;
      full_mode = 1'b1;
      repeat_en = 1'b1;
      prg_bank_q[0] = '0;
      prg_bank_q[1] = '0;
      for (int i = 0; i < 8; i++) chr_bank_q[i] = 12'(i);
      mirror_q = '0;
      misc_q = 2'd1;
      irq_latch = '0;
      irq_ctl = '0;
      irq_cnt = '0;
      presc = 0;
      irq_pend = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_LINE0_MASK:   sel0_mask = cfg_wdata;
          CFG_LINE1_MASK:   sel1_mask = cfg_wdata;
          CFG_FULL_VARIANT: full_mode = cfg_wdata[0];
          default:          repeat_en = cfg_wdata[0];
        endcase
      end
      if (in_tvalid && in_tready) begin
        want = map_item(mode_t'(in_tuser), in_tdata[15:0], in_tdata[23:16]);
        bank_result_q.push_back(item_typed ? item_want : want);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (bank_result_q.size() == 0) begin
          report_mismatch("unexpected transfer", int'(got), 0);
        end else begin
          want = bank_result_q.pop_front();
          if (got.bank !== want.bank)
            report_mismatch("bank", int'(got.bank), int'(want.bank));
          if (got.mc !== want.mc)
            report_mismatch("mirror_code", int'(got.mc), int'(want.mc));
          if (got.wram !== want.wram)
            report_mismatch("wram_enable", int'(got.wram), int'(want.wram));
          if (got.irq !== want.irq)
            report_mismatch("irq_line", int'(got.irq), int'(want.irq));
        end
        if (got.irq) n_irq_seen++;
        n_results++;
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= (recv_pct == 0) || ($urandom_range(99) >= recv_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input mode_t m, input logic [15:0] a, input logic [7:0] v,
                           input logic typed, input result_t want);
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tuser   <= m;
    in_tdata   <= {v, a};
    item_typed <= typed;
    item_want  <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] d);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= d;
    @(posedge clk);
  endtask

  initial begin
    int          k;
    mode_t       m;
    logic [15:0] a;
    logic [7:0]  v;
    logic [15:0] mask0, mask1;
    logic        full_v, rpt_v;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pct = 23;
    recv_pct = 81;
    for (int i = 0; i < NDIR; i++) begin
      send_item(DIR_TBL[i].m, DIR_TBL[i].a, DIR_TBL[i].v, DIR_TBL[i].typed, DIR_TBL[i].want);
    end
    in_tvalid <= 1'b0;

    for (int ph = 0; ph < NPHASE; ph++) begin
      // Registers change only once the block has drained.
      while (bank_result_q.size() != 0) @(posedge clk);
      repeat (3) @(posedge clk);
      case (ph)
        0: begin mask0 = 16'h0001; mask1 = 16'h0002; full_v = 1'b1; rpt_v = 1'b1; end
        1: begin
          mask0 = 16'($urandom); mask1 = 16'($urandom); full_v = 1'b1; rpt_v = 1'b0;
        end
        2: begin mask0 = 16'h0000; mask1 = 16'h0000; full_v = 1'b1; rpt_v = 1'b1; end
        3: begin mask0 = 16'hFFFF; mask1 = 16'hFFFF; full_v = 1'b0; rpt_v = 1'b0; end
        4: begin mask0 = 16'h0002; mask1 = 16'h0001; full_v = 1'b1; rpt_v = 1'b1; end
        default: begin
          mask0 = 16'($urandom); mask1 = 16'($urandom);
          full_v = 1'($urandom_range(1)); rpt_v = 1'b1;
        end
      endcase
      write_reg(CFG_LINE0_MASK, mask0);
      write_reg(CFG_LINE1_MASK, mask1);
      write_reg(CFG_FULL_VARIANT, {15'd0, full_v});
      write_reg(CFG_HONOR_REPEAT, {15'd0, rpt_v});
      cfg_we <= 1'b0;
      n_cfg++;
      case (ph / 2)
        0: begin send_pct = 23; recv_pct = 81; end
        1: begin send_pct = 81; recv_pct = 23; end
        default: begin send_pct = 0; recv_pct = 0; end
      endcase

      for (int i = 0; i < PHASE_LEN; i++) begin
        k = $urandom_range(99);
        a = 16'($urandom);
        v = 8'($urandom);
        if (k < 35) begin
          m = MODE_TICK;
        end else if (k < 70) begin
          m = MODE_WRITE;
          if ($urandom_range(9) != 0) a[15] = 1'b1;
          // Lean on the IRQ registers so the counter overflows often.
          if (a[15] && $urandom_range(99) < 40) a[15:12] = HI_IRQ;
          if (a[15:12] == HI_IRQ && $urandom_range(1)) v[3:0] = 4'hF;
        end else if (k < 85) begin
          m = MODE_PRG;
        end else begin
          m = MODE_CHR;
        end
        send_item(m, a, v, 1'b0, '0);
      end
      in_tvalid <= 1'b0;
    end

    while (bank_result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d transfers under %0d register settings, idling on both sides.",
             n_results, n_cfg + 1);
    $display("%0d results carried the interrupt line; %0d mismatches.", n_irq_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/bmi_pkg.sv
rtl/core/bmi_decode.sv
rtl/core/bmi_bank_regs.sv
rtl/core/bmi_irq_counter.sv
rtl/core/bank_mapper_with_cycle_irq_unit.sv
dv/bank_mapper_with_cycle_irq_unit_tb.sv
